// ----- rtl/acf_pkg.sv -----
// ----------------------------------------------------------------------------
// acf_pkg: shared types and constants of the averaging circular FIFO
// Field widths, action and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package acf_pkg;

  // Built depth of the slot store
  localparam int DEPTH_DEF = 64;

  // Field widths
  localparam int DATA_W = 32;
  localparam int CAP_W  = 7;
  localparam int SUM_W  = 38;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  // Divider step counter width (one quotient bit per step)
  localparam int DCNT_W = $clog2(SUM_W);

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Action codes (any other code behaves as a query)
  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;     // capture the incoming request
    logic exec;      // apply push, start pop read, set status
    logic pop_upd;   // read data present: finish the pop
    logic div_load;  // load the divider
    logic div_step;  // one quotient bit
    logic out_load;  // move the result into the output register
  } acf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pop_ok;    // latched request is a pop with entries held
    logic div_last;  // divider is on its final step
    logic out_free;  // output register can take a result this cycle
  } acf_stat_t;

endpackage

// ----- rtl/acf_in_if.sv -----
// ----------------------------------------------------------------------------
// acf_in_if: request channel of the averaging circular FIFO
// Valid/ready handshake carrying one push, pop or query request.
// ----------------------------------------------------------------------------
interface acf_in_if;
  import acf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);

endinterface

// ----- rtl/acf_out_if.sv -----
// ----------------------------------------------------------------------------
// acf_out_if: result channel of the averaging circular FIFO
// Valid/ready handshake carrying one result per request.
// ----------------------------------------------------------------------------
interface acf_out_if;
  import acf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic [STAT_W-1:0]        status;
  logic [CAP_W-1:0]         entry_count;
  logic signed [SUM_W-1:0]  entry_sum;
  logic signed [DATA_W-1:0] entry_average;

  modport source (output valid, output popped_value, output status, output entry_count,
                  output entry_sum, output entry_average, input ready);
  modport sink   (input valid, input popped_value, input status, input entry_count,
                  input entry_sum, input entry_average, output ready);

endinterface

// ----- rtl/acf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// acf_cfg_if: configuration write channel of the averaging circular FIFO
// Valid/ready handshake carrying the capacity register value.
// ----------------------------------------------------------------------------
interface acf_cfg_if;
  import acf_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);

endinterface

// ----- rtl/averaging_circular_fifo.sv -----
// ----------------------------------------------------------------------------
// averaging_circular_fifo: circular FIFO with running sum and average
// Requests arrive on in_if (action: push, pop or query; value for push).
// Each request gives exactly one result on out_if: popped value (-1 unless
// a good pop), status (ok, pop from empty, push into full refused), entry
// count, entry sum and the sum divided by the count, truncated toward zero
// (0 when empty).
// cfg_if writes the capacity (1..DEPTH slots in use; 0 acts as 1, larger
// values as DEPTH). A write empties the queue; it is ready whenever out of
// reset and is meant to be written while no request is in flight.
// A request passes through execute, a slot RAM read (good pop only), the
// 38-step serial divider for the average and the output register. A new
// request is taken once the result is in the output register, so the block
// works on one request at a time.
// If out_if stalls, the result waits in the output register while the next
// request is accepted and worked; that one then holds until the register
// frees. Reset empties the queue and sets capacity to 64; slot contents
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module averaging_circular_fifo #(
  parameter int DEPTH = acf_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  acf_in_if.sink    in_if,
  acf_out_if.source out_if,
  acf_cfg_if.sink   cfg_if
);
  import acf_pkg::*;

  acf_cmd_t  cmd;
  acf_stat_t stat;
  logic      in_ready;

  // Configuration writes are taken at once, nothing is taken in reset
  assign cfg_if.ready = rst_n;
  assign in_if.ready  = in_ready && rst_n;

  acf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  acf_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_valid         (cfg_if.valid),
    .cfg_capacity      (cfg_if.capacity),
    .in_action         (in_if.action),
    .in_value          (in_if.value),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_popped_value  (out_if.popped_value),
    .out_status        (out_if.status),
    .out_entry_count   (out_if.entry_count),
    .out_entry_sum     (out_if.entry_sum),
    .out_entry_average (out_if.entry_average)
  );

endmodule

// ----- rtl/acf_ram.sv -----
// ----------------------------------------------------------------------------
// acf_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module acf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/acf_ctrl.sv -----
// ----------------------------------------------------------------------------
// acf_ctrl: sequencing state machine of the averaging circular FIFO
// Takes one request at a time, steps the datapath through execute, pop
// read, division and result hand-off.
// ----------------------------------------------------------------------------
module acf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output acf_pkg::acf_cmd_t  cmd,
  input  acf_pkg::acf_stat_t stat
);
  import acf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_READ  = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.pop_ok ? S_READ : S_START;
      end
      S_READ: begin
        cmd.pop_upd = 1'b1;
        state_nxt   = S_START;
      end
      S_START: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/acf_dp.sv -----
// ----------------------------------------------------------------------------
// acf_dp: datapath of the averaging circular FIFO
// Ring pointers, count, running sum, slot RAM, serial divider for the
// average and the output register.
// ----------------------------------------------------------------------------
module acf_dp #(
  parameter int DEPTH = acf_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  acf_pkg::acf_cmd_t                cmd,
  output acf_pkg::acf_stat_t               stat,
  input  logic                             cfg_valid,
  input  logic [acf_pkg::CAP_W-1:0]        cfg_capacity,
  input  logic [acf_pkg::ACT_W-1:0]        in_action,
  input  logic signed [acf_pkg::DATA_W-1:0] in_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [acf_pkg::DATA_W-1:0] out_popped_value,
  output logic [acf_pkg::STAT_W-1:0]       out_status,
  output logic [acf_pkg::CAP_W-1:0]        out_entry_count,
  output logic signed [acf_pkg::SUM_W-1:0] out_entry_sum,
  output logic signed [acf_pkg::DATA_W-1:0] out_entry_average
);
  import acf_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
  localparam logic [CAP_W-1:0] DEPTH_CAP =
    (DEPTH > (2**CAP_W) - 1) ? CAP_W'((2**CAP_W) - 1) : CAP_W'(DEPTH);

  // Ring state
  logic [CAP_W-1:0]         cap_r, cap_nxt;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [IDX_W-1:0]         tail_r, tail_nxt;
  logic [CAP_W-1:0]         count_r, count_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;

  // Latched request and per-request result
  logic [ACT_W-1:0]         act_r;
  logic signed [DATA_W-1:0] val_r;
  logic [STAT_W-1:0]        status_r;
  logic signed [DATA_W-1:0] popped_r;

  // Divider
  logic [SUM_W-1:0]         dq_r;
  logic [CAP_W-1:0]         rem_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic                     neg_r;
  logic [CAP_W:0]           trial;
  logic                     trial_ge;
  logic [SUM_W-1:0]         mag;
  logic [SUM_W-1:0]         quot;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] o_popped_r;
  logic [STAT_W-1:0]        o_status_r;
  logic [CAP_W-1:0]         o_count_r;
  logic signed [SUM_W-1:0]  o_sum_r;
  logic signed [DATA_W-1:0] o_avg_r;

  logic [CAP_W-1:0]         eff_cap;
  logic                     is_push, is_pop, full, push_ok, pop_ok;
  logic [DATA_W-1:0]        ram_rdata;

  // Ring index advance, wrapping at the effective capacity
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CAP_W-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(idx) + CW'(1);
    return (n >= CW'(cap)) ? '0 : idx + IDX_W'(1);
  endfunction

  // Capacity clamped to 1..built depth
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CAP_W'(1);
    end else if (cap_r > DEPTH_CAP) begin
      eff_cap = DEPTH_CAP;
    end else begin
      eff_cap = cap_r;
    end
  end

  // Request decode
  assign is_push = (act_r == ACT_PUSH);
  assign is_pop  = (act_r == ACT_POP);
  assign full    = (count_r >= eff_cap);
  assign push_ok = is_push && !full;
  assign pop_ok  = is_pop && (count_r != '0);

  // Slot store
  acf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.exec && push_ok),
    .waddr (tail_r),
    .wdata (val_r),
    .re    (cmd.exec && pop_ok),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // Ring pointer, count and running sum update
  always_comb begin
    cap_nxt   = cap_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (cfg_valid) begin
      cap_nxt   = cfg_capacity;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (cmd.exec && push_ok) begin
      tail_nxt  = next_idx(tail_r, eff_cap);
      count_nxt = count_r + CAP_W'(1);
      sum_nxt   = sum_r + SUM_W'(val_r);
    end else if (cmd.pop_upd) begin
      head_nxt  = next_idx(head_r, eff_cap);
      count_nxt = count_r - CAP_W'(1);
      sum_nxt   = sum_r - SUM_W'($signed(ram_rdata));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Request capture, status and popped value
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_action;
      val_r <= in_value;
    end
    if (cmd.exec) begin
      popped_r <= '1;
      if (is_push && full) begin
        status_r <= ST_FULL;
      end else if (is_pop && !pop_ok) begin
        status_r <= ST_EMPTY;
      end else begin
        status_r <= ST_OK;
      end
    end else if (cmd.pop_upd) begin
      popped_r <= $signed(ram_rdata);
    end
  end

  // Restoring divider: |sum| / count, one quotient bit per step
  assign mag      = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign trial    = {rem_r, dq_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, count_r});
  assign quot     = neg_r ? (~dq_r + SUM_W'(1)) : dq_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq_r   <= mag;
      rem_r  <= '0;
      dcnt_r <= '0;
      neg_r  <= sum_r[SUM_W-1];
    end else if (cmd.div_step) begin
      dq_r   <= {dq_r[SUM_W-2:0], trial_ge};
      rem_r  <= trial_ge ? CAP_W'(trial - {1'b0, count_r}) : trial[CAP_W-1:0];
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_popped_r <= popped_r;
      o_status_r <= status_r;
      o_count_r  <= count_r;
      o_sum_r    <= sum_r;
      o_avg_r    <= (count_r == '0) ? '0 : $signed(quot[DATA_W-1:0]);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_popped_value  = o_popped_r;
  assign out_status        = o_status_r;
  assign out_entry_count   = o_count_r;
  assign out_entry_sum     = o_sum_r;
  assign out_entry_average = o_avg_r;

  // Status to controller
  assign stat.pop_ok   = pop_ok;
  assign stat.div_last = (dcnt_r == DCNT_W'(SUM_W - 1));
  assign stat.out_free = !out_valid_r || out_ready;

`ifndef NO_ASSERTIONS
  // Count never passes the effective capacity
  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= eff_cap)
    else $error("entry count above capacity");

  // An empty ring has a zero running sum
  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (sum_r == '0))
    else $error("running sum nonzero while empty");

  // An empty ring has head and tail together
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("head and tail apart while empty");

  // A finished pop leaves one entry fewer unless a capacity write comes in the same cycle
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_upd && !cfg_valid) |=> (count_r == $past(count_r) - CAP_W'(1)))
    else $error("pop did not decrement count");
`endif

endmodule

// ----- bench/tb_averaging_circular_fifo.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_averaging_circular_fifo: self-checking bench for the averaging FIFO
// Walks a short table of directed requests and capacity writes, then runs
// random push/pop/query traffic over several capacities; both handshake
// sides idle at random. Each result is checked field by field against the
// table's values if given, else a model of ring, sum and truncated average.
// ----------------------------------------------------------------------------
module tb_averaging_circular_fifo;
  import acf_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 10;
  localparam int IDX_W           = $clog2(DEPTH_DEF);
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int CALM_PHASE      = 6;
  localparam int HOLD_PHASE      = 3;
  localparam int PAUSE_PHASE     = 1;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int END_WAIT        = 60;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 10;

  // Action code outside the defined set; the block treats it as a query
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] popped;
    logic [STAT_W-1:0] status;
    logic [CAP_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [DATA_W-1:0] avg;
  } fifo_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [ACT_W-1:0]  act;
    logic [DATA_W-1:0] val;
    bit                typed;
    fifo_result_t      res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  acf_in_if  in_bus ();
  acf_out_if out_bus ();
  acf_cfg_if cfg_bus ();

  averaging_circular_fifo u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  // Model state of the ring
  logic [DATA_W-1:0]       slots [DEPTH_DEF];
  logic [IDX_W-1:0]        head_idx;
  logic [IDX_W-1:0]        tail_idx;
  logic [CAP_W-1:0]        held_cnt;
  logic signed [SUM_W-1:0] run_total;
  logic [CAP_W-1:0]        cap_reg;

  fifo_result_t pending_results [$];
  stim_row_t    stim_table [$];

  // Typed expectation travelling with the request on the bus
  bit           req_typed;
  fifo_result_t req_typed_res;

  bit calm;
  int hold_left;
  int fail_count;
  int report_count;
  int n_req, n_results, n_cfg, n_full, n_empty;

  // Clock
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Ring model
  // ---------------------------------------------------------------------------
  function automatic logic [CAP_W-1:0] eff_capacity();
    if (cap_reg == '0) return CAP_W'(1);
    if (cap_reg > DEPTH_DEF) return CAP_W'(DEPTH_DEF);
    return cap_reg;
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] idx);
    logic [CAP_W-1:0] n;
    n = CAP_W'(idx) + CAP_W'(1);
    return (n >= eff_capacity()) ? '0 : n[IDX_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] widen(logic [DATA_W-1:0] v);
    return {{(SUM_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic void clear_ring();
    head_idx  = '0;
    tail_idx  = '0;
    held_cnt  = '0;
    run_total = '0;
  endfunction

  function automatic fifo_result_t fifo_apply(logic [ACT_W-1:0] act,
                                              logic [DATA_W-1:0] val);
    fifo_result_t r;
    longint       total;
    r.popped = '1;
    r.status = ST_OK;
    r.avg    = '0;
    if (act == ACT_PUSH) begin
      if (held_cnt >= eff_capacity()) begin
        r.status = ST_FULL;
      end else begin
        slots[tail_idx] = val;
        run_total = run_total + widen(val);
        tail_idx  = next_slot(tail_idx);
        held_cnt  = held_cnt + 1'b1;
      end
    end else if (act == ACT_POP) begin
      if (held_cnt == '0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped  = slots[head_idx];
        run_total = run_total - widen(slots[head_idx]);
        head_idx  = next_slot(head_idx);
        held_cnt  = held_cnt - 1'b1;
      end
    end
    // signed division truncates toward zero
    if (held_cnt != '0) begin
      total = run_total;
      r.avg = DATA_W'(total / longint'(held_cnt));
    end
    r.count = held_cnt;
    r.sum   = run_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic void add_req(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val);
    stim_row_t row;
    row.kind  = ROW_REQ;
    row.act   = act;
    row.val   = val;
    row.typed = 1'b0;
    row.res   = '0;
    stim_table.push_back(row);
  endfunction

  function automatic void add_chk(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val,
                                  int pop, logic [STAT_W-1:0] st, int cnt,
                                  longint sm, int av);
    stim_row_t row;
    row.kind       = ROW_REQ;
    row.act        = act;
    row.val        = val;
    row.typed      = 1'b1;
    row.res.popped = DATA_W'(pop);
    row.res.status = st;
    row.res.count  = CAP_W'(cnt);
    row.res.sum    = SUM_W'(sm);
    row.res.avg    = DATA_W'(av);
    stim_table.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CAP_W-1:0] cap);
    stim_row_t row;
    row.kind  = ROW_CFG;
    row.act   = ACT_QUERY;
    row.val   = DATA_W'(cap);
    row.typed = 1'b0;
    row.res   = '0;
    stim_table.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4:       return DATA_W'($urandom_range(200)) - DATA_W'(100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(bit filling);
    int r;
    r = $urandom_range(99);
    if (r >= 97) return ACT_SPARE;
    if (r >= 88) return ACT_QUERY;
    if (filling) return (r < 70) ? ACT_PUSH : ACT_POP;
    return (r < 20) ? ACT_PUSH : ACT_POP;
  endfunction

  function automatic logic [CAP_W-1:0] phase_capacity(int ph);
    case (ph)
      0:       return CAP_W'(64);
      1:       return CAP_W'(1);
      2:       return CAP_W'(3);
      3:       return CAP_W'(127);
      4:       return CAP_W'(0);
      5:       return CAP_W'(2);
      6:       return CAP_W'($urandom_range(4, 16));
      7:       return CAP_W'($urandom_range(17, 127));
      8:       return CAP_W'(100);
      default: return CAP_W'(64);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_req(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val,
                          bit typed, fifo_result_t res);
    while (!calm && $urandom_range(99) < 7) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid  = 1'b1;
    in_bus.action = act;
    in_bus.value  = val;
    req_typed     = typed;
    req_typed_res = res;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and let every outstanding request come back
  task automatic drain_requests();
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_requests();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_bus.valid    = 1'b1;
    cfg_bus.capacity = cap;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver: random back-pressure plus a counted long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else begin
        out_bus.ready = calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: update model on every accepted request, check every result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fifo_result_t predicted;
    fifo_result_t want;
    fifo_result_t got;

    if (rst_n && cfg_bus.valid && cfg_bus.ready) begin
      cap_reg = cfg_bus.capacity;
      clear_ring();
      n_cfg++;
    end

    if (rst_n && in_bus.valid && in_bus.ready) begin
      predicted = fifo_apply(in_bus.action, in_bus.value);
      if (predicted.status == ST_FULL) n_full++;
      if (predicted.status == ST_EMPTY) n_empty++;
      pending_results.push_back(req_typed ? req_typed_res : predicted);
      n_req++;
    end

    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.popped = out_bus.popped_value;
      got.status = out_bus.status;
      got.count  = out_bus.entry_count;
      got.sum    = out_bus.entry_sum;
      got.avg    = out_bus.entry_average;
      n_results++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("ERROR %0t: result with no request outstanding", $realtime);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.popped !== want.popped || got.status !== want.status ||
            got.count !== want.count || got.sum !== want.sum ||
            got.avg !== want.avg) begin
          fail_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("MISMATCH %0t result %0d: exp pop=%0d st=%0d cnt=%0d sum=%0d avg=%0d",
                     $realtime, n_results, $signed(want.popped), want.status,
                     want.count, $signed(want.sum), $signed(want.avg));
            $display("  got pop=%0d st=%0d cnt=%0d sum=%0d avg=%0d",
                     $signed(got.popped), got.status, got.count,
                     $signed(got.sum), $signed(got.avg));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles with no handshake on any channel
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    bit        filling;
    int        stretch;

    // Known values on every input from time zero
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.action    = ACT_QUERY;
    in_bus.value     = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.capacity = '0;
    req_typed        = 1'b0;
    req_typed_res    = '0;
    calm             = 1'b0;
    hold_left        = 0;
    fail_count       = 0;
    report_count     = 0;
    n_req = 0; n_results = 0; n_cfg = 0; n_full = 0; n_empty = 0;

    // Model reset state
    foreach (slots[i]) slots[i] = '0;
    cap_reg = CAP_RESET;
    clear_ring();

    // Directed table: after reset, field extremes, spare action, full/empty,
    // capacity 0 and above depth, wrap of the ring, write while entries held
    add_chk(ACT_QUERY, '0, -1, ST_OK, 0, 0, 0);
    add_chk(ACT_POP, '0, -1, ST_EMPTY, 0, 0, 0);
    add_chk(ACT_SPARE, '1, -1, ST_OK, 0, 0, 0);
    add_chk(ACT_PUSH, 32'h7FFF_FFFF, -1, ST_OK, 1, 2147483647, 2147483647);
    add_chk(ACT_PUSH, 32'h8000_0000, -1, ST_OK, 2, -1, 0);
    add_chk(ACT_PUSH, -32'sd7, -1, ST_OK, 3, -8, -2);
    add_req(ACT_POP, '0);
    add_req(ACT_POP, '1);
    add_chk(ACT_POP, '0, -7, ST_OK, 0, 0, 0);
    add_chk(ACT_POP, '0, -1, ST_EMPTY, 0, 0, 0);
    add_cfg(CAP_W'(1));
    add_chk(ACT_PUSH, 32'd5, -1, ST_OK, 1, 5, 5);
    add_chk(ACT_PUSH, 32'd6, -1, ST_FULL, 1, 5, 5);
    add_chk(ACT_POP, '0, 5, ST_OK, 0, 0, 0);
    add_cfg(CAP_W'(0));
    add_chk(ACT_PUSH, '1, -1, ST_OK, 1, -1, -1);
    add_chk(ACT_PUSH, '0, -1, ST_FULL, 1, -1, -1);
    add_req(ACT_QUERY, 32'h5555_5555);
    add_cfg(CAP_W'(2));
    add_req(ACT_PUSH, 32'd100);
    add_req(ACT_PUSH, 32'd201);
    add_req(ACT_PUSH, 32'd3);
    add_req(ACT_POP, '0);
    add_req(ACT_PUSH, -32'sd50);
    add_req(ACT_POP, '0);
    add_req(ACT_POP, '0);
    add_req(ACT_POP, '0);
    add_cfg(CAP_W'(127));
    add_req(ACT_PUSH, 32'h8000_0000);
    add_req(ACT_PUSH, 32'd1);
    add_cfg(CAP_W'(3));
    add_chk(ACT_QUERY, '0, -1, ST_OK, 0, 0, 0);

    // Reset
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_CFG)
        write_capacity(row.val[CAP_W-1:0]);
      else
        send_req(row.act, row.val, row.typed, row.res);
    end

    // Random phases: alternating fill and drain stretches per capacity
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_capacity(ph));
      calm    = (ph == CALM_PHASE);
      filling = 1'b1;
      stretch = $urandom_range(20, 90);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // receiver holds off while requests keep coming
        if (ph == HOLD_PHASE && k == 60) hold_left = HOLD_CYCLES;
        // sender waits for every result before going on
        if (ph == PAUSE_PHASE && k == 80) drain_requests();
        if (stretch == 0) begin
          filling = !filling;
          stretch = $urandom_range(20, 90);
        end
        stretch--;
        send_req(pick_action(filling), pick_value(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    // Wind down
    drain_requests();
    repeat (END_WAIT) @(negedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d results never arrived", pending_results.size());
    end

    $display("Checked %0d results for %0d requests over %0d capacity writes",
             n_results, n_req, n_cfg);
    $display("  including %0d refused pushes into a full ring and %0d pops from empty",
             n_full, n_empty);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/acf_pkg.sv
rtl/acf_in_if.sv
rtl/acf_out_if.sv
rtl/acf_cfg_if.sv
rtl/acf_ram.sv
rtl/acf_ctrl.sv
rtl/acf_dp.sv
rtl/averaging_circular_fifo.sv
bench/tb_averaging_circular_fifo.sv
